[hw/rtl/etu_pkg.sv]
package etu_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int LIMIT_W     = 16;
	localparam int CMP_W       = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

	localparam int Q_DEPTH = 4;
	localparam int QPTR_W  = $clog2(Q_DEPTH);

	// Escape sequence state held between beats.
	localparam logic [2:0] PK_NONE   = 3'd0;
	localparam logic [2:0] PK_PCT    = 3'd1;
	localparam logic [2:0] PK_PCT2   = 3'd2;
	localparam logic [2:0] PK_CARET  = 3'd3;
	localparam logic [2:0] PK_DOLLAR = 3'd4;

	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_TWO    = 8'h32;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	// One decoded input beat: up to three results for the back end.
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      nres;
		logic            has;
		logic            last;
		logic [15:0]     total;
	} etu_entry_t;

endpackage

[hw/rtl/etu_if.sv]
interface etu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface etu_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic        has_byte;
	logic        out_last;
	logic [15:0] out_total;

	modport source (output valid, output out_byte, output has_byte, output out_last,
		output out_total, input ready);
	modport sink (input valid, input out_byte, input has_byte, input out_last,
		input out_total, output ready);
endinterface

[hw/rtl/escaped_text_unescaper_unit.sv]
// Decodes an escaped byte stream at up to one input beat per cycle: "%20" gives a space,
// "^^" gives '^', "^$" gives '&' and "$$" gives '$', everything else passes literally, and
// held escape bytes are flushed on the beat marked in_last. An input beat is decoded in the
// cycle it is accepted and parked in a four-entry queue; the output stage then sends one
// result beat per cycle while dout.ready is high, so a beat that yields two or three bytes
// occupies the output for one result beat per byte and the queue absorbs that until it
// fills, when din.ready drops. A result passes through its queue entry and then the output
// register before it is offered on dout. At most out_limit bytes are sent per message, and
// the message's final result carries out_last and the byte count in out_total, as a pure
// end marker with has_byte low if nothing else is left to send. out_limit resets to 65535
// and should be written only while no beats are in flight.
module escaped_text_unescaper_unit
	import etu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	etu_in_if.sink      din,
	etu_out_if.source   dout,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	logic [15:0] out_limit_q;
	logic        q_full;
	logic        push;
	etu_entry_t  push_data;
	logic        pop;
	logic        head_valid;
	etu_entry_t  head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_limit_q <= 16'hFFFF;
		end else if (cfg_we) begin
			out_limit_q <= cfg_wdata;
		end
	end

	etu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.din       (din),
		.out_limit (out_limit_q),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	etu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	etu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.dout       (dout)
	);

endmodule

[hw/rtl/etu_front.sv]
module etu_front
	import etu_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	etu_in_if.sink       din,
	input  logic [15:0]  out_limit,
	input  logic         q_full,
	output logic         push,
	output etu_entry_t   push_data
);

	logic [2:0]             pending_q;
	logic [COUNT_WIDTH-1:0] count_q;

	logic [2:0]       pending_nxt;
	logic [2:0][7:0]  buf_b;
	logic [1:0]       n;
	logic [1:0]       nh;
	logic             fresh;
	logic             is_opener;
	logic [2:0]       opener_code;
	logic [CMP_W-1:0] lim_ext;
	logic [CMP_W-1:0] cmax_ext;
	logic [CMP_W-1:0] lim_eff;
	logic [CMP_W-1:0] cnt_ext;
	logic [CMP_W-1:0] avail;
	logic [1:0]       k;
	logic [CMP_W-1:0] sum;
	logic             accept;

	assign din.ready = !q_full;
	assign accept    = din.valid && din.ready;

	always_comb begin
		is_opener   = 1'b0;
		opener_code = PK_NONE;
		case (din.in_byte)
			CH_PCT: begin
				is_opener   = 1'b1;
				opener_code = PK_PCT;
			end
			CH_CARET: begin
				is_opener   = 1'b1;
				opener_code = PK_CARET;
			end
			CH_DOLLAR: begin
				is_opener   = 1'b1;
				opener_code = PK_DOLLAR;
			end
			default: begin
				is_opener   = 1'b0;
				opener_code = PK_NONE;
			end
		endcase
	end

	// Held bytes go first; a broken escape then looks at the new byte afresh.
	always_comb begin
		buf_b       = '0;
		nh          = 2'd0;
		n           = 2'd0;
		fresh       = 1'b0;
		pending_nxt = PK_NONE;
		case (pending_q)
			PK_PCT: begin
				if (din.in_byte == CH_TWO && !din.in_last) begin
					pending_nxt = PK_PCT2;
				end else begin
					buf_b[0] = CH_PCT;
					nh       = 2'd1;
					fresh    = 1'b1;
				end
			end
			PK_PCT2: begin
				if (din.in_byte == CH_ZERO) begin
					buf_b[0] = CH_SPACE;
					n        = 2'd1;
				end else begin
					buf_b[0] = CH_PCT;
					buf_b[1] = CH_TWO;
					nh       = 2'd2;
					fresh    = 1'b1;
				end
			end
			PK_CARET: begin
				if (din.in_byte == CH_CARET) begin
					buf_b[0] = CH_CARET;
					n        = 2'd1;
				end else if (din.in_byte == CH_DOLLAR) begin
					buf_b[0] = CH_AMP;
					n        = 2'd1;
				end else begin
					buf_b[0] = CH_CARET;
					nh       = 2'd1;
					fresh    = 1'b1;
				end
			end
			PK_DOLLAR: begin
				if (din.in_byte == CH_DOLLAR) begin
					buf_b[0] = CH_DOLLAR;
					n        = 2'd1;
				end else begin
					buf_b[0] = CH_DOLLAR;
					nh       = 2'd1;
					fresh    = 1'b1;
				end
			end
			default: begin
				fresh = 1'b1;
			end
		endcase
		if (fresh) begin
			n = nh;
			if (!din.in_last && is_opener) begin
				pending_nxt = opener_code;
			end else begin
				buf_b[nh] = din.in_byte;
				n         = nh + 2'd1;
			end
		end
		if (din.in_last) begin
			pending_nxt = PK_NONE;
		end
	end

	// Only as many bytes as the limit leaves room for are passed on.
	always_comb begin
		lim_ext  = CMP_W'(out_limit);
		cmax_ext = CMP_W'({COUNT_WIDTH{1'b1}});
		lim_eff  = (lim_ext < cmax_ext) ? lim_ext : cmax_ext;
		cnt_ext  = CMP_W'(count_q);
		avail    = (cnt_ext >= lim_eff) ? '0 : (lim_eff - cnt_ext);
		k        = (CMP_W'(n) < avail) ? n : avail[1:0];
		sum      = cnt_ext + CMP_W'(k);
	end

	always_comb begin
		push_data.bytes = buf_b;
		push_data.has   = (k != 2'd0);
		push_data.nres  = (k == 2'd0) ? 2'd1 : k;
		push_data.last  = din.in_last;
		push_data.total = sum[15:0];
		push            = accept && ((k != 2'd0) || din.in_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= PK_NONE;
			count_q   <= '0;
		end else if (accept) begin
			pending_q <= pending_nxt;
			count_q   <= din.in_last ? '0 : sum[COUNT_WIDTH-1:0];
		end
	end

endmodule

[hw/rtl/etu_queue.sv]
module etu_queue
	import etu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  etu_entry_t push_data,
	output logic       full,
	input  logic       pop,
	output logic       head_valid,
	output etu_entry_t head
);

	etu_entry_t        mem_q [Q_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   fill_q;

	assign full       = (fill_q == (QPTR_W+1)'(Q_DEPTH));
	assign head_valid = (fill_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

[hw/rtl/etu_back.sv]
module etu_back
	import etu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  etu_entry_t head,
	output logic       pop,
	etu_out_if.source  dout
);

	logic [1:0]  idx_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        has_byte_q;
	logic        out_last_q;
	logic [15:0] out_total_q;

	logic load;
	logic end_of_entry;
	logic is_last;

	assign load         = head_valid && (!out_valid_q || dout.ready);
	assign end_of_entry = (idx_q == (head.nres - 2'd1));
	assign is_last      = head.last && end_of_entry;
	assign pop          = load && end_of_entry;

	assign dout.valid     = out_valid_q;
	assign dout.out_byte  = out_byte_q;
	assign dout.has_byte  = has_byte_q;
	assign dout.out_last  = out_last_q;
	assign dout.out_total = out_total_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q  <= head.has ? head.bytes[idx_q] : 8'd0;
			has_byte_q  <= head.has;
			out_last_q  <= is_last;
			out_total_q <= is_last ? head.total : 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			idx_q       <= end_of_entry ? 2'd0 : (idx_q + 2'd1);
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

[tb/escaped_text_unescaper_unit_tb.sv]
`timescale 1ns / 100ps

module escaped_text_unescaper_unit_tb;
	import etu_pkg::*;

	typedef struct packed {
		logic [7:0]  data;
		logic        has;
		logic        last;
		logic [15:0] total;
	} decoded_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       typed;
		decoded_t   want;
	} stim_row_t;

	localparam int N_ROWS       = 26;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 90;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	etu_in_if  din_if();
	etu_out_if dout_if();

	escaped_text_unescaper_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.din       (din_if),
		.dout      (dout_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Decoder state mirrored by the testbench.
	logic [2:0]             held_kind;
	logic [COUNT_WIDTH-1:0] msg_count;
	logic [15:0]            limit_val;
	logic [7:0]             lit_bytes [3];
	int                     lit_n;

	decoded_t  expected_q [$];
	stim_row_t rows [N_ROWS];

	int errors;
	int cycles;
	bit src_steady;
	bit sink_steady;
	bit hold_req;
	bit hold_taken;
	int hold_left;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic void add_literal(input logic [7:0] b);
		lit_bytes[lit_n] = b;
		lit_n++;
	endfunction

	// A byte seen with nothing held either opens an escape or is literal.
	function automatic void open_or_literal(input logic [7:0] b, input logic l);
		if (!l && b == CH_PCT) begin
			held_kind = PK_PCT;
		end else if (!l && b == CH_CARET) begin
			held_kind = PK_CARET;
		end else if (!l && b == CH_DOLLAR) begin
			held_kind = PK_DOLLAR;
		end else begin
			add_literal(b);
		end
	endfunction

	function automatic void decode_beat(input logic [7:0] b, input logic l);
		logic [2:0] kind;
		int         made;
		decoded_t   r;
		kind = held_kind;
		held_kind = PK_NONE;
		lit_n = 0;
		made = 0;
		case (kind)
			PK_PCT: begin
				if (b == CH_TWO && !l) begin
					held_kind = PK_PCT2;
				end else begin
					add_literal(CH_PCT);
					open_or_literal(b, l);
				end
			end
			PK_PCT2: begin
				if (b == CH_ZERO) begin
					add_literal(CH_SPACE);
				end else begin
					add_literal(CH_PCT);
					add_literal(CH_TWO);
					open_or_literal(b, l);
				end
			end
			PK_CARET: begin
				if (b == CH_CARET) begin
					add_literal(CH_CARET);
				end else if (b == CH_DOLLAR) begin
					add_literal(CH_AMP);
				end else begin
					add_literal(CH_CARET);
					open_or_literal(b, l);
				end
			end
			PK_DOLLAR: begin
				add_literal(CH_DOLLAR);
				if (b != CH_DOLLAR)
					open_or_literal(b, l);
			end
			default: begin
				open_or_literal(b, l);
			end
		endcase
		for (int i = 0; i < lit_n; i++) begin
			if (msg_count < limit_val && msg_count != '1) begin
				msg_count++;
				r = '{lit_bytes[i], 1'b1, 1'b0, 16'd0};
				expected_q.push_back(r);
				made++;
			end
		end
		if (l) begin
			if (made == 0) begin
				r = '{8'h00, 1'b0, 1'b1, msg_count[15:0]};
			end else begin
				r = expected_q.pop_back();
				r.last = 1'b1;
				r.total = msg_count[15:0];
			end
			expected_q.push_back(r);
			held_kind = PK_NONE;
			msg_count = '0;
		end
	endfunction

	// Called at a rising edge; returns at the edge where the beat is taken.
	task automatic offer_beat(input logic [7:0] b, input logic l, input logic typed,
		input decoded_t want);
		int mark;
		while (!src_steady && $urandom_range(99) < 25) begin
			din_if.valid <= 1'b0;
			@(posedge clk);
		end
		din_if.valid <= 1'b1;
		din_if.in_byte <= b;
		din_if.in_last <= l;
		@(posedge clk);
		while (!din_if.ready)
			@(posedge clk);
		mark = expected_q.size();
		decode_beat(b, l);
		if (typed) begin
			while (expected_q.size() > mark)
				void'(expected_q.pop_back());
			expected_q.push_back(want);
		end
	endtask

	task automatic send_message(input int len, output int sent);
		logic [7:0] text [$];
		int         pick;
		while (text.size() < len) begin
			pick = $urandom_range(99);
			if (pick < 35) begin
				case ($urandom_range(3))
					0: begin
						text.push_back(CH_PCT);
						text.push_back(CH_TWO);
						text.push_back(CH_ZERO);
					end
					1: begin
						text.push_back(CH_CARET);
						text.push_back(CH_CARET);
					end
					2: begin
						text.push_back(CH_CARET);
						text.push_back(CH_DOLLAR);
					end
					default: begin
						text.push_back(CH_DOLLAR);
						text.push_back(CH_DOLLAR);
					end
				endcase
			end else if (pick < 60) begin
				case ($urandom_range(4))
					0: text.push_back(CH_PCT);
					1: text.push_back(CH_TWO);
					2: text.push_back(CH_ZERO);
					3: text.push_back(CH_CARET);
					default: text.push_back(CH_DOLLAR);
				endcase
			end else begin
				text.push_back(8'($urandom_range(255)));
			end
		end
		foreach (text[i])
			offer_beat(text[i], i == text.size() - 1, 1'b0, '0);
		sent = text.size();
	endtask

	task automatic run_phase(input int items);
		int done_items;
		int n;
		done_items = 0;
		while (done_items < items) begin
			send_message($urandom_range(1, 12), n);
			done_items += n;
		end
	endtask

	// The block is idle once every result is back and the drain wait is over.
	task automatic set_limit(input logic [15:0] v);
		din_if.valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		limit_val = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 16'd0;
		din_if.valid <= 1'b0;
		din_if.in_byte <= 8'h00;
		din_if.in_last <= 1'b0;
		held_kind = PK_NONE;
		msg_count = '0;
		limit_val = 16'hFFFF;
		errors = 0;
		src_steady = 1'b0;
		sink_steady = 1'b0;
		hold_req = 1'b0;
		rows = '{
			'{8'h41,     1'b0, 1'b1, '{8'h41, 1'b1, 1'b0, 16'd0}},
			'{8'h42,     1'b1, 1'b1, '{8'h42, 1'b1, 1'b1, 16'd2}},
			'{8'h00,     1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 16'd1}},
			'{8'hFF,     1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, 16'd1}},
			'{CH_PCT,    1'b0, 1'b0, '0},
			'{CH_TWO,    1'b0, 1'b0, '0},
			'{CH_ZERO,   1'b1, 1'b1, '{CH_SPACE, 1'b1, 1'b1, 16'd1}},
			'{CH_CARET,  1'b0, 1'b0, '0},
			'{CH_CARET,  1'b0, 1'b0, '0},
			'{CH_CARET,  1'b0, 1'b0, '0},
			'{CH_DOLLAR, 1'b0, 1'b0, '0},
			'{CH_DOLLAR, 1'b0, 1'b0, '0},
			'{CH_DOLLAR, 1'b1, 1'b1, '{CH_DOLLAR, 1'b1, 1'b1, 16'd3}},
			'{CH_PCT,    1'b0, 1'b0, '0},
			'{8'h78,     1'b0, 1'b0, '0},
			'{CH_PCT,    1'b0, 1'b0, '0},
			'{CH_TWO,    1'b0, 1'b0, '0},
			'{CH_CARET,  1'b0, 1'b0, '0},
			'{CH_PCT,    1'b0, 1'b0, '0},
			'{CH_TWO,    1'b1, 1'b0, '0},
			'{CH_CARET,  1'b1, 1'b1, '{CH_CARET, 1'b1, 1'b1, 16'd1}},
			'{CH_DOLLAR, 1'b0, 1'b0, '0},
			'{CH_PCT,    1'b1, 1'b0, '0},
			'{CH_PCT,    1'b0, 1'b0, '0},
			'{CH_TWO,    1'b0, 1'b0, '0},
			'{CH_DOLLAR, 1'b1, 1'b0, '0}
		};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			offer_beat(rows[i].data, rows[i].last, rows[i].typed, rows[i].want);

		set_limit(16'd0);
		run_phase(55);
		set_limit(16'd1);
		run_phase(55);
		set_limit(16'd3);
		run_phase(55);

		src_steady = 1'b1;
		sink_steady = 1'b1;
		set_limit(16'hFFFF);
		run_phase(60);
		src_steady = 1'b0;
		sink_steady = 1'b0;

		// Long output stall while input keeps coming, to fill the queue.
		hold_req = 1'b1;
		run_phase(60);

		set_limit(16'($urandom_range(2, 12)));
		run_phase(60);
		set_limit(16'($urandom_range(65535)));
		run_phase(60);

		din_if.valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("escaped_text_unescaper_unit_tb: done, clean");
		else
			$display("escaped_text_unescaper_unit_tb: done, errors");
		$finish;
	end

	initial begin
		dout_if.ready <= 1'b0;
		hold_left = 0;
		hold_taken = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				dout_if.ready <= 1'b0;
				hold_left--;
			end else if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = HOLD_CYCLES;
				dout_if.ready <= 1'b0;
			end else if (sink_steady) begin
				dout_if.ready <= 1'b1;
			end else begin
				dout_if.ready <= ($urandom_range(99) >= 25);
			end
		end
	end

	always @(posedge clk) begin : check_results
		decoded_t want;
		if (arst_n && dout_if.valid && dout_if.ready) begin
			if (expected_q.size() == 0) begin
				errors++;
				if (errors < 50)
					$display("%0t: unexpected result, got byte %02h has %0d last %0d total %0d",
						$time, dout_if.out_byte, dout_if.has_byte, dout_if.out_last,
						dout_if.out_total);
			end else begin
				want = expected_q.pop_front();
				if (dout_if.out_byte !== want.data || dout_if.has_byte !== want.has ||
					dout_if.out_last !== want.last || dout_if.out_total !== want.total) begin
					errors++;
					if (errors < 50)
						$display("%0t: expected byte %02h has %0d last %0d total %0d, got %02h %0d %0d %0d",
							$time, want.data, want.has, want.last, want.total,
							dout_if.out_byte, dout_if.has_byte, dout_if.out_last,
							dout_if.out_total);
				end
			end
		end
	end

	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("escaped_text_unescaper_unit_tb: done, errors");
			$finish;
		end
	end

endmodule
